// File: src/assert_macros.svh
// Assertion helpers, clocked on clk_i, off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Expression must never be true.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)

`endif

// File: src/m3i_pkg.sv
`timescale 1ns / 1ps
package m3i_pkg;
  localparam int EL_W   = 32;  // element width
  localparam int PROD_W = 64;  // element product
  localparam int COF_W  = 65;  // cofactor, signed
  localparam int MAG_W  = 64;  // cofactor magnitude
  localparam int DET_W  = 98;  // determinant, signed
  localparam int THR_W  = 31;  // threshold register
  localparam int QB     = 33;  // quotient bits produced by a lane

  typedef struct packed {
    logic [EL_W-1:0] val;
    logic            ovf;
    logic            sing;
  } lane_res_t;
endpackage

// File: src/m3i_cofactor.sv
`timescale 1ns / 1ps
module m3i_cofactor
  import m3i_pkg::*;
(
  input  logic                     clk_i,
  input  logic signed [EL_W-1:0]   pa_i,
  input  logic signed [EL_W-1:0]   pb_i,
  input  logic signed [EL_W-1:0]   qa_i,
  input  logic signed [EL_W-1:0]   qb_i,
  output logic signed [COF_W-1:0]  cof_o
);
  logic signed [PROD_W-1:0] p_q, q_q;
  logic signed [COF_W-1:0]  cof_q;

  always_ff @(posedge clk_i) begin
    p_q   <= pa_i * pb_i;
    q_q   <= qa_i * qb_i;
    cof_q <= COF_W'(p_q) - COF_W'(q_q);
  end

  assign cof_o = cof_q;
endmodule

// File: src/m3i_det.sv
`timescale 1ns / 1ps
module m3i_det
  import m3i_pkg::*;
(
  input  logic                     clk_i,
  input  logic signed [EL_W-1:0]   row_i [3],
  input  logic signed [COF_W-1:0]  cof_i [3],
  output logic signed [DET_W-1:0]  dt_o
);
  logic signed [EL_W-1:0]  e1_q [3];
  logic signed [EL_W-1:0]  e2_q [3];
  logic [PROD_W-1:0]       pl_q [3];
  logic [PROD_W-1:0]       ph_q [3];
  logic                    neg_q [3];
  logic signed [DET_W-1:0] dt_q;
  logic [EL_W-1:0]         am [3];
  logic [MAG_W-1:0]        cm [3];
  logic signed [DET_W-1:0] term [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      am[k] = e2_q[k][EL_W-1] ? EL_W'(-e2_q[k]) : EL_W'(e2_q[k]);
      cm[k] = cof_i[k][COF_W-1] ? MAG_W'(-cof_i[k]) : MAG_W'(cof_i[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      term[k] = DET_W'({ph_q[k], 32'd0}) + DET_W'(pl_q[k]);
      if (neg_q[k]) term[k] = -term[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      e1_q[k]  <= row_i[k];
      e2_q[k]  <= e1_q[k];
      pl_q[k]  <= am[k] * cm[k][31:0];
      ph_q[k]  <= am[k] * cm[k][63:32];
      neg_q[k] <= e2_q[k][EL_W-1] ^ cof_i[k][COF_W-1];
    end
    dt_q <= term[0] + term[1] + term[2];
  end

  assign dt_o = dt_q;
endmodule

// File: src/m3i_div_lane.sv
`timescale 1ns / 1ps
module m3i_div_lane
  import m3i_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter bit DIAG      = 1'b0
) (
  input  logic                     clk_i,
  input  logic signed [COF_W-1:0]  cof_i,
  input  logic signed [DET_W-1:0]  dt_i,
  input  logic [DET_W-1:0]         dmag_i,
  input  logic                     sing_i,
  output lane_res_t                res_o
);
  localparam int NUM_W = (2*FRAC_BITS+66 > DET_W) ? 2*FRAC_BITS+66 : DET_W;
  localparam int W     = NUM_W + 1;

  logic signed [COF_W-1:0] c1_q, c2_q;
  logic [MAG_W-1:0]        cmag;
  logic [W-1:0]            num, rem0, dw;
  logic                    ovf0;

  logic [DET_W-1:0] rem_q [QB+1];
  logic [DET_W-1:0] d_q   [QB+1];
  logic [QB-1:0]    lo_q  [QB+1];
  logic [QB-1:0]    qa_q  [QB+1];
  logic             neg_q [QB+1];
  logic             ovf_q [QB+1];
  logic             sg_q  [QB+1];
  lane_res_t        res_q, res_d;

  assign cmag = c2_q[COF_W-1] ? MAG_W'(-c2_q) : MAG_W'(c2_q);
  assign num  = (W'(cmag) << (2*FRAC_BITS+1)) + W'(dmag_i);
  assign dw   = W'({dmag_i[DET_W-2:0], 1'b0});
  assign rem0 = num >> QB;
  assign ovf0 = rem0 >= dw;

  always_ff @(posedge clk_i) begin
    c1_q      <= cof_i;
    c2_q      <= c1_q;
    rem_q[0]  <= ovf0 ? '0 : rem0[DET_W-1:0];
    d_q[0]    <= dw[DET_W-1:0];
    lo_q[0]   <= num[QB-1:0];
    qa_q[0]   <= '0;
    neg_q[0]  <= c2_q[COF_W-1] ^ dt_i[DET_W-1];
    ovf_q[0]  <= ovf0;
    sg_q[0]   <= sing_i;
  end

  // one quotient bit per stage, MSB first
  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [DET_W:0] cand, diff;
    logic           ge;
    assign cand = {rem_q[s], lo_q[s][QB-1-s]};
    assign diff = cand - {1'b0, d_q[s]};
    assign ge   = cand >= {1'b0, d_q[s]};
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= ge ? diff[DET_W-1:0] : cand[DET_W-1:0];
      d_q[s+1]   <= d_q[s];
      lo_q[s+1]  <= lo_q[s];
      qa_q[s+1]  <= {qa_q[s][QB-2:0], ge};
      neg_q[s+1] <= neg_q[s];
      ovf_q[s+1] <= ovf_q[s];
      sg_q[s+1]  <= sg_q[s];
    end
  end

  always_comb begin
    res_d.sing = sg_q[QB];
    res_d.ovf  = 1'b0;
    res_d.val  = '0;
    if (sg_q[QB]) begin
      res_d.val = DIAG ? EL_W'(64'd1 << FRAC_BITS) : '0;
    end else if (neg_q[QB]) begin
      if (ovf_q[QB] || qa_q[QB] > QB'(64'h8000_0000)) begin
        res_d.val = 32'h8000_0000;
        res_d.ovf = 1'b1;
      end else begin
        res_d.val = -qa_q[QB][EL_W-1:0];
      end
    end else begin
      if (ovf_q[QB] || qa_q[QB] > QB'(64'h7FFF_FFFF)) begin
        res_d.val = 32'h7FFF_FFFF;
        res_d.ovf = 1'b1;
      end else begin
        res_d.val = qa_q[QB][EL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;
endmodule

// File: src/matrix3_inverse.sv
`timescale 1ns / 1ps
// 3x3 matrix inverse by adjugate, signed fixed point (FRAC_BITS fraction bits).
// Input: pulse start_i with the nine elements in_rXcY_i; a transfer happens
//   on a clock edge with start_i high and busy_o low. busy_o is always low:
//   a new matrix may be sent every cycle.
// Output: done_o is high for one cycle with inv_rXcY_o, singular_o and
//   overflow_o. The receiver cannot stall; results come out in order.
// Throughput: one matrix per cycle.
// Pipeline: cofactor products and their difference, determinant, a setup
//   stage, restoring division (one quotient bit per stage in each of nine
//   parallel lanes), saturation and merge.
// Singular: |det| >> 2*FRAC_BITS <= zero threshold gives the identity and
//   singular_o; overflow_o reports any saturated element.
// Config: cfg_we_i writes cfg_wdata_i to the zero threshold (reset 1); write
//   only while no matrix is in flight.
// Reset: clears the valid pipeline and sets the threshold back to 1; data in
//   flight is lost.
module matrix3_inverse
  import m3i_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    cfg_we_i,
  input  logic [THR_W-1:0]        cfg_wdata_i,
  input  logic signed [EL_W-1:0]  in_r0c0_i,
  input  logic signed [EL_W-1:0]  in_r0c1_i,
  input  logic signed [EL_W-1:0]  in_r0c2_i,
  input  logic signed [EL_W-1:0]  in_r1c0_i,
  input  logic signed [EL_W-1:0]  in_r1c1_i,
  input  logic signed [EL_W-1:0]  in_r1c2_i,
  input  logic signed [EL_W-1:0]  in_r2c0_i,
  input  logic signed [EL_W-1:0]  in_r2c1_i,
  input  logic signed [EL_W-1:0]  in_r2c2_i,
  output logic                    done_o,
  output logic signed [EL_W-1:0]  inv_r0c0_o,
  output logic signed [EL_W-1:0]  inv_r0c1_o,
  output logic signed [EL_W-1:0]  inv_r0c2_o,
  output logic signed [EL_W-1:0]  inv_r1c0_o,
  output logic signed [EL_W-1:0]  inv_r1c1_o,
  output logic signed [EL_W-1:0]  inv_r1c2_o,
  output logic signed [EL_W-1:0]  inv_r2c0_o,
  output logic signed [EL_W-1:0]  inv_r2c1_o,
  output logic signed [EL_W-1:0]  inv_r2c2_o,
  output logic                    singular_o,
  output logic                    overflow_o
);
  `include "assert_macros.svh"

  localparam int LAT = 40;

  logic signed [EL_W-1:0]  el [9];
  logic signed [COF_W-1:0] cof [9];
  logic signed [EL_W-1:0]  row0 [3];
  logic signed [COF_W-1:0] cof_row0 [3];
  logic signed [DET_W-1:0] dt;
  logic [DET_W-1:0]        dmag, scaled;
  logic                    sing;
  lane_res_t               res [9];

  logic [THR_W-1:0] thr_q;
  logic [LAT-1:0]   vld_q;
  logic [EL_W-1:0]  out_q [9];
  logic             sing_q, ovf_q;
  logic             ovf_any;

  assign busy_o = 1'b0;

  assign el[0] = in_r0c0_i; assign el[1] = in_r0c1_i; assign el[2] = in_r0c2_i;
  assign el[3] = in_r1c0_i; assign el[4] = in_r1c1_i; assign el[5] = in_r1c2_i;
  assign el[6] = in_r2c0_i; assign el[7] = in_r2c1_i; assign el[8] = in_r2c2_i;

  // cofactor (i,j) = e[i+1][j+1]*e[i+2][j+2] - e[i+1][j+2]*e[i+2][j+1], indices mod 3
  for (genvar i = 0; i < 3; i++) begin : g_ci
    for (genvar j = 0; j < 3; j++) begin : g_cj
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      localparam int J1 = (j + 1) % 3;
      localparam int J2 = (j + 2) % 3;
      m3i_cofactor u_cof (
        .clk_i (clk_i),
        .pa_i  (el[I1*3+J1]),
        .pb_i  (el[I2*3+J2]),
        .qa_i  (el[I1*3+J2]),
        .qb_i  (el[I2*3+J1]),
        .cof_o (cof[i*3+j])
      );
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_row0
    assign row0[k]     = el[k];
    assign cof_row0[k] = cof[k];
  end

  m3i_det u_det (
    .clk_i (clk_i),
    .row_i (row0),
    .cof_i (cof_row0),
    .dt_o  (dt)
  );

  // singular test on the truncated Q-format magnitude
  assign dmag   = dt[DET_W-1] ? DET_W'(-dt) : DET_W'(dt);
  assign scaled = dmag >> (2*FRAC_BITS);
  assign sing   = scaled <= DET_W'(thr_q);

  // lane (i,j) divides cofactor (j,i), i.e. the adjugate
  for (genvar i = 0; i < 3; i++) begin : g_li
    for (genvar j = 0; j < 3; j++) begin : g_lj
      m3i_div_lane #(
        .FRAC_BITS (FRAC_BITS),
        .DIAG      (i == j)
      ) u_lane (
        .clk_i  (clk_i),
        .cof_i  (cof[j*3+i]),
        .dt_i   (dt),
        .dmag_i (dmag),
        .sing_i (sing),
        .res_o  (res[i*3+j])
      );
    end
  end

  // merge: gather elements, fold the lane overflow flags
  always_comb begin
    ovf_any = 1'b0;
    for (int k = 0; k < 9; k++) ovf_any = ovf_any | res[k].ovf;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 9; k++) out_q[k] <= res[k].val;
    sing_q <= res[0].sing;
    ovf_q  <= ovf_any;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(1);
      vld_q <= '0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      vld_q <= {vld_q[LAT-2:0], start_i & ~busy_o};
    end
  end

  assign done_o     = vld_q[LAT-1];
  assign inv_r0c0_o = out_q[0];
  assign inv_r0c1_o = out_q[1];
  assign inv_r0c2_o = out_q[2];
  assign inv_r1c0_o = out_q[3];
  assign inv_r1c1_o = out_q[4];
  assign inv_r1c2_o = out_q[5];
  assign inv_r2c0_o = out_q[6];
  assign inv_r2c1_o = out_q[7];
  assign inv_r2c2_o = out_q[8];
  assign singular_o = sing_q;
  assign overflow_o = ovf_q;

  `ASSERT_CLK(a_latency, start_i |-> ##40 done_o, "result missing after fixed latency")
  `ASSERT_NEVER(a_sing_ovf, done_o && singular_o && overflow_o, "singular result flagged overflow")
  `ASSERT_CLK(a_sing_id, (done_o && singular_o) |-> (inv_r0c1_o == '0 && inv_r1c0_o == '0), "singular result not identity")
endmodule
